// ===== rtl/core/numbered_string_line_parser_assert.svh =====
// Assertion macros shared by the line parser modules.
`ifndef NUMBERED_STRING_LINE_PARSER_ASSERT_SVH
`define NUMBERED_STRING_LINE_PARSER_ASSERT_SVH

`ifndef SYNTH

// Check a property on every rising edge of clk outside reset.
`define NSLP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define NSLP_NEVER(name, cond, msg) \
    `NSLP_ASSERT(name, !(cond), msg)

`else

`define NSLP_ASSERT(name, prop, msg)

`define NSLP_NEVER(name, cond, msg)

`endif

`endif

// ===== rtl/core/nslp_pkg.sv =====
// Types, constants and helper functions of the numbered string line parser.
`default_nettype none

package nslp_pkg;

    // Ids saturate at this value, which is never emitted.
    localparam int ID_SPACE = 4096;
    localparam int ID_W     = $clog2(ID_SPACE + 1);
    localparam int LIMIT_W  = 13;
    localparam logic [LIMIT_W-1:0] ID_LIMIT_RESET = 13'd4096;

    // Depth of the operation queue between front and back.
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
    localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_A  = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6e;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [4:0] NO_DIGIT = 5'd16;

    typedef enum logic [3:0] {
        PH_WS   = 4'd0,
        PH_SIGN = 4'd1,
        PH_ZERO = 4'd2,
        PH_HEXX = 4'd3,
        PH_NUM  = 4'd4,
        PH_SEEK = 4'd5,
        PH_STR  = 4'd6,
        PH_SKIP = 4'd7,
        PH_DONE = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_buffer;
    } nslp_in_t;

    typedef struct packed {
        logic [11:0] string_id;
        logic [7:0]  char_out;
        logic        end_of_string;
    } nslp_out_t;

    // One queued operation: up to three result beats of one input beat.
    typedef struct packed {
        logic [11:0]     id;
        logic [1:0]      cnt;
        logic [2:0][7:0] ch;
        logic            eos;
    } nslp_op_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_break(logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_dec(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Digit value of c in base b, or NO_DIGIT.
    function automatic logic [4:0] digit_of(logic [7:0] c, base_t b);
        logic [4:0] d;
        d = NO_DIGIT;
        if (c >= CH_0 && c <= CH_9) d = 5'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF_A) d = 5'(c - CH_LA + 8'd10);
        else if (c >= CH_UA && c <= CH_UF) d = 5'(c - CH_UA + 8'd10);
        if (b == BASE_DEC && d > 5'd9) d = NO_DIGIT;
        if (b == BASE_OCT && d > 5'd7) d = NO_DIGIT;
        return d;
    endfunction

    function automatic logic id_ok(logic [ID_W-1:0] id, logic [LIMIT_W-1:0] limit);
        return (id != '0) && (LIMIT_W'(id) < limit) && (id < ID_W'(ID_SPACE));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nslp_front.sv =====
// Front part: byte parser that turns each accepted beat into at most one queued operation.
`default_nettype none

module nslp_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire nslp_pkg::nslp_in_t           item,
    input  wire logic [nslp_pkg::LIMIT_W-1:0] id_limit,
    output logic                              op_push,
    output nslp_pkg::nslp_op_t                op
);

    localparam int MW = nslp_pkg::ID_W + 4;

    nslp_pkg::phase_t              phase_reg, phase_next;
    logic [nslp_pkg::ID_W-1:0]     id_reg, id_next;
    nslp_pkg::base_t               base_reg, base_next;
    logic                          vld_reg, vld_next;
    logic                          esc_reg, esc_next;
    logic                          pbs_reg, pbs_next;
    logic                          ended_reg, ended_next;

    logic [1:0]                    n_cnt;
    logic [2:0][7:0]               e_ch;
    logic                          e_eos;
    logic [11:0]                   e_id;

    always_comb
    begin
        logic [7:0]            c;
        logic                  fin;
        nslp_pkg::phase_t      fin_ph;
        logic [4:0]            d;
        logic [MW-1:0]         acc;
        c          = item.text_byte;
        fin        = 1'b0;
        fin_ph     = phase_reg;
        d          = nslp_pkg::NO_DIGIT;
        acc        = '0;
        phase_next = phase_reg;
        id_next    = id_reg;
        base_next  = base_reg;
        vld_next   = vld_reg;
        esc_next   = esc_reg;
        pbs_next   = pbs_reg;
        ended_next = ended_reg;
        n_cnt      = 2'd0;
        e_ch       = '0;
        e_eos      = 1'b0;

        if (phase_reg == nslp_pkg::PH_DONE || ended_reg)
        begin
            // text over: drop bytes until the buffer ends
        end
        else if (c == nslp_pkg::CH_NUL)
        begin
            fin        = 1'b1;
            fin_ph     = phase_reg;
            phase_next = nslp_pkg::PH_DONE;
            ended_next = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                nslp_pkg::PH_WS:
                begin
                    if (nslp_pkg::is_space(c))
                    begin
                        phase_next = nslp_pkg::PH_WS;
                    end
                    else if (c == nslp_pkg::CH_PLUS)
                    begin
                        phase_next = nslp_pkg::PH_SIGN;
                    end
                    else if (nslp_pkg::is_dec(c))
                    begin
                        id_next    = nslp_pkg::ID_W'(c - nslp_pkg::CH_0);
                        base_next  = nslp_pkg::BASE_DEC;
                        vld_next   = 1'b0;
                        phase_next = (c == nslp_pkg::CH_0) ? nslp_pkg::PH_ZERO
                                                           : nslp_pkg::PH_NUM;
                    end
                    else
                    begin
                        phase_next = nslp_pkg::PH_SKIP;
                    end
                end
                nslp_pkg::PH_SIGN:
                begin
                    if (nslp_pkg::is_dec(c))
                    begin
                        id_next    = nslp_pkg::ID_W'(c - nslp_pkg::CH_0);
                        base_next  = nslp_pkg::BASE_DEC;
                        vld_next   = 1'b0;
                        phase_next = (c == nslp_pkg::CH_0) ? nslp_pkg::PH_ZERO
                                                           : nslp_pkg::PH_NUM;
                    end
                    else
                    begin
                        phase_next = nslp_pkg::is_break(c) ? nslp_pkg::PH_WS
                                                           : nslp_pkg::PH_SKIP;
                    end
                end
                nslp_pkg::PH_ZERO, nslp_pkg::PH_NUM:
                begin
                    if (phase_reg == nslp_pkg::PH_ZERO &&
                        (c == nslp_pkg::CH_LX || c == nslp_pkg::CH_UX))
                    begin
                        base_next  = nslp_pkg::BASE_HEX;
                        phase_next = nslp_pkg::PH_HEXX;
                    end
                    else if (phase_reg == nslp_pkg::PH_ZERO &&
                             c >= nslp_pkg::CH_0 && c <= nslp_pkg::CH_7)
                    begin
                        base_next  = nslp_pkg::BASE_OCT;
                        id_next    = nslp_pkg::ID_W'(c - nslp_pkg::CH_0);
                        phase_next = nslp_pkg::PH_NUM;
                    end
                    else if (phase_reg == nslp_pkg::PH_NUM &&
                             nslp_pkg::digit_of(c, base_reg) != nslp_pkg::NO_DIGIT)
                    begin
                        // scale by the base with shifts, then saturate
                        d = nslp_pkg::digit_of(c, base_reg);
                        unique case (base_reg)
                            nslp_pkg::BASE_HEX: acc = MW'(id_reg) << 4;
                            nslp_pkg::BASE_OCT: acc = MW'(id_reg) << 3;
                            default:            acc = (MW'(id_reg) << 3) + (MW'(id_reg) << 1);
                        endcase
                        acc = acc + MW'(d);
                        id_next = (acc > MW'(nslp_pkg::ID_SPACE))
                                ? nslp_pkg::ID_W'(nslp_pkg::ID_SPACE)
                                : acc[nslp_pkg::ID_W-1:0];
                    end
                    else
                    begin
                        vld_next = nslp_pkg::id_ok(id_reg, id_limit);
                        if (nslp_pkg::is_break(c))
                        begin
                            fin        = 1'b1;
                            fin_ph     = phase_reg;
                            phase_next = nslp_pkg::PH_WS;
                        end
                        else if (c == nslp_pkg::CH_QUOTE)
                        begin
                            phase_next = nslp_pkg::PH_STR;
                            esc_next   = 1'b0;
                            pbs_next   = 1'b0;
                        end
                        else
                        begin
                            phase_next = nslp_pkg::PH_SEEK;
                        end
                    end
                end
                nslp_pkg::PH_HEXX:
                begin
                    d = nslp_pkg::digit_of(c, nslp_pkg::BASE_HEX);
                    if (d != nslp_pkg::NO_DIGIT)
                    begin
                        id_next    = nslp_pkg::ID_W'(d);
                        phase_next = nslp_pkg::PH_NUM;
                    end
                    else
                    begin
                        id_next    = '0;
                        vld_next   = 1'b0;
                        phase_next = nslp_pkg::is_break(c) ? nslp_pkg::PH_WS
                                                           : nslp_pkg::PH_SKIP;
                    end
                end
                nslp_pkg::PH_SEEK:
                begin
                    if (nslp_pkg::is_break(c))
                    begin
                        fin        = 1'b1;
                        fin_ph     = nslp_pkg::PH_SEEK;
                        phase_next = nslp_pkg::PH_WS;
                    end
                    else if (c == nslp_pkg::CH_QUOTE)
                    begin
                        phase_next = nslp_pkg::PH_STR;
                        esc_next   = 1'b0;
                        pbs_next   = 1'b0;
                    end
                end
                nslp_pkg::PH_STR:
                begin
                    if (nslp_pkg::is_break(c) || (c == nslp_pkg::CH_QUOTE && !pbs_reg))
                    begin
                        fin        = 1'b1;
                        fin_ph     = nslp_pkg::PH_STR;
                        phase_next = nslp_pkg::is_break(c) ? nslp_pkg::PH_WS
                                                           : nslp_pkg::PH_SKIP;
                    end
                    else
                    begin
                        pbs_next = (c == nslp_pkg::CH_BSL);
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                            if (vld_reg)
                            begin
                                if (c == nslp_pkg::CH_QUOTE || c == nslp_pkg::CH_BSL)
                                begin
                                    e_ch[0] = c;
                                    n_cnt   = 2'd1;
                                end
                                else if (c == nslp_pkg::CH_LN)
                                begin
                                    e_ch[0] = nslp_pkg::CH_LF;
                                    n_cnt   = 2'd1;
                                end
                                else
                                begin
                                    e_ch[0] = nslp_pkg::CH_BSL;
                                    e_ch[1] = c;
                                    n_cnt   = 2'd2;
                                end
                            end
                        end
                        else if (c == nslp_pkg::CH_BSL)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (vld_reg)
                        begin
                            e_ch[0] = c;
                            n_cnt   = 2'd1;
                        end
                    end
                end
                nslp_pkg::PH_SKIP:
                begin
                    if (nslp_pkg::is_break(c))
                        phase_next = nslp_pkg::PH_WS;
                end
                default:
                begin
                    phase_next = nslp_pkg::PH_WS;
                end
            endcase
        end

        // buffer end closes a number or string still open
        if (item.end_of_buffer && !fin &&
            phase_next != nslp_pkg::PH_DONE && !ended_next)
        begin
            fin    = 1'b1;
            fin_ph = phase_next;
        end

        if (fin)
        begin
            if (fin_ph == nslp_pkg::PH_ZERO || fin_ph == nslp_pkg::PH_NUM)
                vld_next = nslp_pkg::id_ok(id_next, id_limit);
            if (fin_ph inside {nslp_pkg::PH_ZERO, nslp_pkg::PH_NUM,
                               nslp_pkg::PH_SEEK, nslp_pkg::PH_STR} && vld_next)
            begin
                if (fin_ph == nslp_pkg::PH_STR && esc_next)
                begin
                    e_ch[n_cnt] = nslp_pkg::CH_BSL;
                    n_cnt       = n_cnt + 2'd1;
                end
                e_ch[n_cnt] = nslp_pkg::CH_NUL;
                n_cnt       = n_cnt + 2'd1;
                e_eos       = 1'b1;
            end
            esc_next = 1'b0;
            pbs_next = 1'b0;
        end

        e_id = id_next[11:0];

        if (item.end_of_buffer)
        begin
            phase_next = nslp_pkg::PH_WS;
            id_next    = '0;
            base_next  = nslp_pkg::BASE_DEC;
            vld_next   = 1'b0;
            esc_next   = 1'b0;
            pbs_next   = 1'b0;
            ended_next = 1'b0;
        end
    end

    always_comb
    begin
        op_push = accept && (n_cnt != 2'd0);
        op.id   = e_id;
        op.cnt  = n_cnt;
        op.ch   = e_ch;
        op.eos  = e_eos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nslp_pkg::PH_WS;
            id_reg    <= '0;
            base_reg  <= nslp_pkg::BASE_DEC;
            vld_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            pbs_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            base_reg  <= base_next;
            vld_reg   <= vld_next;
            esc_reg   <= esc_next;
            pbs_reg   <= pbs_next;
            ended_reg <= ended_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nslp_opq.sv =====
// Short operation queue between the parser front and the result back.
`default_nettype none

`include "numbered_string_line_parser_assert.svh"

module nslp_opq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_en,
    input  wire nslp_pkg::nslp_op_t push_op,
    output logic                    full,
    output logic                    head_valid,
    output nslp_pkg::nslp_op_t      head_op,
    input  wire logic               pop_en
);

    nslp_pkg::nslp_op_t                entry_reg [nslp_pkg::OPQ_DEPTH];
    logic [nslp_pkg::OPQ_AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [nslp_pkg::OPQ_CW-1:0]       count_reg, count_next;

    assign full       = (count_reg == nslp_pkg::OPQ_CW'(nslp_pkg::OPQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_en && !pop_en)
            count_next = count_reg + nslp_pkg::OPQ_CW'(1);
        else if (!push_en && pop_en)
            count_next = count_reg - nslp_pkg::OPQ_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_en)
                wr_ptr_reg <= wr_ptr_reg + nslp_pkg::OPQ_AW'(1);
            if (pop_en)
                rd_ptr_reg <= rd_ptr_reg + nslp_pkg::OPQ_AW'(1);
            count_reg <= count_next;
        end
    end

    `NSLP_NEVER(a_opq_overflow, push_en && full, "operation queue overflow")
    `NSLP_NEVER(a_opq_underflow, pop_en && !head_valid, "operation queue underflow")
    `NSLP_ASSERT(a_opq_count, count_reg <= nslp_pkg::OPQ_CW'(nslp_pkg::OPQ_DEPTH), "bad count")

endmodule

`default_nettype wire

// ===== rtl/core/nslp_back.sv =====
// Back part: expands queued operations into result beats behind an output register.
`default_nettype none

`include "numbered_string_line_parser_assert.svh"

module nslp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire nslp_pkg::nslp_op_t head_op,
    output logic                    head_pop,
    output logic                    empty,
    input  wire logic               pop,
    output nslp_pkg::nslp_out_t     result
);

    logic [1:0]          idx_reg, idx_next;
    logic                out_vld_reg, out_vld_next;
    nslp_pkg::nslp_out_t out_reg, out_next;
    logic                load;
    logic                is_last;

    assign load     = head_valid && (!out_vld_reg || pop);
    assign is_last  = (idx_reg == head_op.cnt - 2'd1);
    assign head_pop = load && is_last;
    assign empty    = !out_vld_reg;
    assign result   = out_reg;

    always_comb
    begin
        idx_next     = idx_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (load)
        begin
            out_next.string_id     = head_op.id;
            out_next.char_out      = head_op.ch[idx_reg];
            out_next.end_of_string = head_op.eos && is_last;
            out_vld_next           = 1'b1;
            idx_next               = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= 2'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            out_vld_reg <= out_vld_next;
        end
    end

    `NSLP_ASSERT(a_back_idx_range, head_valid |-> (idx_reg < head_op.cnt), "beat index past operation")
    `NSLP_ASSERT(a_back_idle_idx, !head_valid |-> (idx_reg == 2'd0), "beat index left mid operation")
    `NSLP_ASSERT(a_back_term_zero, (out_vld_reg && out_reg.end_of_string) |-> (out_reg.char_out == 8'd0), "terminator not zero")

endmodule

`default_nettype wire

// ===== rtl/core/numbered_string_line_parser.sv =====
// Top level of the numbered string line parser.
//
//  channel  direction  handshake            beat
//  -------  ---------  -------------------  -------------------------------------
//  input    in         push / full          item: text_byte, end_of_buffer
//  result   out        empty / pop          result: string_id, char_out, end_of_string
//  config   in         cfg_valid/cfg_ready  cfg_data: id_limit
//
//  One input beat is parsed per cycle while full is low; a beat yields zero to three result beats.
//  Results leave through the output register at one beat per cycle while they are
//  popped, so the rate is set by the back part, which sends a beat's results in turn.
//  The parser front stalls (full) only when the four-entry operation queue is full.
//  Reset clears the parse state and sets id_limit to 4096; no clearing pass is needed.
//  The first result beat passes through the operation queue and then the output
//  register before it shows on the result ports.
`default_nettype none

module numbered_string_line_parser (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire nslp_pkg::nslp_in_t           item,
    output logic                              empty,
    input  wire logic                         pop,
    output nslp_pkg::nslp_out_t               result,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [nslp_pkg::LIMIT_W-1:0] cfg_data
);

    logic [nslp_pkg::LIMIT_W-1:0] limit_reg;
    logic                         accept;
    logic                         op_push;
    nslp_pkg::nslp_op_t           op;
    logic                         q_full;
    logic                         head_valid;
    nslp_pkg::nslp_op_t           head_op;
    logic                         head_pop;

    // The limit register takes a beat in any cycle.
    assign cfg_ready = 1'b1;

    // Accept a byte whenever the queue has room for its operation.
    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= nslp_pkg::ID_LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    // Front: parse the byte, classify it and build the operation.
    nslp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .id_limit (limit_reg),
        .op_push  (op_push),
        .op       (op)
    );

    // Queue: decouple parsing from result delivery.
    nslp_opq u_opq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (op_push),
        .push_op    (op),
        .full       (q_full),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop_en     (head_pop)
    );

    // Back: advance through each operation one result beat at a time.
    nslp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire
